>>> rtl/irpd_pkg.sv
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types and constants of the infrared pulse-distance decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  localparam logic [1:0] REG_PAIR_THRESHOLD     = 2'd0;
  localparam logic [1:0] REG_END_GAP            = 2'd1;
  localparam logic [1:0] REG_SPACE_TIMEOUT      = 2'd2;
  localparam logic [1:0] REG_FIRST_BIT_INTERVAL = 2'd3;

  localparam logic [16:0] RST_PAIR_THRESHOLD     = 17'd175;
  localparam logic [15:0] RST_END_GAP            = 16'd5625;
  localparam logic [15:0] RST_SPACE_TIMEOUT      = 16'd6250;
  localparam logic [7:0]  RST_FIRST_BIT_INTERVAL = 8'd20;

  localparam logic [7:0]  INDEX_MAX = 8'hFF;
  localparam logic [15:0] TICK_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [16:0] pair_threshold;
    logic [15:0] end_gap;
    logic [15:0] space_timeout;
    logic [7:0]  first_bit_interval;
  } cfg_t;

  typedef struct packed {
    logic [7:0] command;
    logic [7:0] frame_intervals;
  } res_t;

endpackage

>>> rtl/irpd_if.sv
// ----------------------------------------------------------------------------
// irpd_in_if / irpd_out_if
// Valid/ready channels for pin samples and decoded frames.
// ----------------------------------------------------------------------------
interface irpd_in_if;
  logic valid;
  logic ready;
  logic ir_level;

  modport source (output valid, output ir_level, input ready);
  modport sink (input valid, input ir_level, output ready);
endinterface

interface irpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] command;
  logic [7:0] frame_intervals;

  modport source (output valid, output command, output frame_intervals, input ready);
  modport sink (input valid, input command, input frame_intervals, output ready);
endinterface

>>> rtl/irpd_regs.sv
// ----------------------------------------------------------------------------
// irpd_regs
// APB configuration registers of the decoder.
// ----------------------------------------------------------------------------
module irpd_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [irpd_pkg::AddrWidth-1:0] paddr,
  input  logic [irpd_pkg::DataWidth-1:0] pwdata,
  output logic [irpd_pkg::DataWidth-1:0] prdata,
  output logic                           pready,
  output irpd_pkg::cfg_t                 cfg_o
);

  irpd_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [1:0]     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pair_threshold     <= irpd_pkg::RST_PAIR_THRESHOLD;
      cfg_q.end_gap            <= irpd_pkg::RST_END_GAP;
      cfg_q.space_timeout      <= irpd_pkg::RST_SPACE_TIMEOUT;
      cfg_q.first_bit_interval <= irpd_pkg::RST_FIRST_BIT_INTERVAL;
    end else if (wr_en) begin
      case (reg_sel)
        irpd_pkg::REG_PAIR_THRESHOLD:     cfg_q.pair_threshold     <= pwdata[16:0];
        irpd_pkg::REG_END_GAP:            cfg_q.end_gap            <= pwdata[15:0];
        irpd_pkg::REG_SPACE_TIMEOUT:      cfg_q.space_timeout      <= pwdata[15:0];
        irpd_pkg::REG_FIRST_BIT_INTERVAL: cfg_q.first_bit_interval <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      irpd_pkg::REG_PAIR_THRESHOLD:     prdata = 32'(cfg_q.pair_threshold);
      irpd_pkg::REG_END_GAP:            prdata = 32'(cfg_q.end_gap);
      irpd_pkg::REG_SPACE_TIMEOUT:      prdata = 32'(cfg_q.space_timeout);
      irpd_pkg::REG_FIRST_BIT_INTERVAL: prdata = 32'(cfg_q.first_bit_interval);
      default:                          prdata = '0;
    endcase
  end

endmodule

>>> rtl/irpd_interval.sv
// ----------------------------------------------------------------------------
// irpd_interval
// Books one finished interval: holds the first of a pair, decides a bit on
// the second, and advances the saturating interval index.
// ----------------------------------------------------------------------------
module irpd_interval #(
  parameter int unsigned COMMAND_BITS = 8
) (
  input  irpd_pkg::cfg_t          cfg_i,
  input  logic [7:0]              idx_i,
  input  logic [15:0]             ticks_i,
  input  logic [15:0]             held_i,
  input  logic [COMMAND_BITS-1:0] cmd_i,
  output logic [7:0]              idx_o,
  output logic [15:0]             held_o,
  output logic [COMMAND_BITS-1:0] cmd_o
);

  logic [7:0]  rel;
  logic [6:0]  pair;
  logic [16:0] sum;
  logic        bit_one;

  always_comb begin
    idx_o   = idx_i;
    held_o  = held_i;
    cmd_o   = cmd_i;
    rel     = idx_i - cfg_i.first_bit_interval;
    pair    = rel[7:1];
    sum     = {1'b0, held_i} + {1'b0, ticks_i};
    bit_one = sum > cfg_i.pair_threshold;
    if (idx_i != irpd_pkg::INDEX_MAX) begin
      idx_o = idx_i + 8'd1;
      if (idx_i >= cfg_i.first_bit_interval) begin
        if (!rel[0]) begin
          held_o = ticks_i;
        end else begin
          for (int b = 0; b < COMMAND_BITS; b++) begin
            if (7'(COMMAND_BITS - 1 - b) == pair) begin
              cmd_o[b] = bit_one;
            end
          end
        end
      end
    end
  end

endmodule

>>> rtl/irpd_core.sv
// ----------------------------------------------------------------------------
// irpd_core
// Frame state of the decoder: times marks and spaces, books intervals and
// flags the end of a frame.
// ----------------------------------------------------------------------------
module irpd_core #(
  parameter int unsigned COMMAND_BITS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  irpd_pkg::cfg_t cfg_i,
  input  logic           step_i,
  input  logic           level_i,
  output logic           emit_o,
  output irpd_pkg::res_t res_o
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_MARK  = 2'd1;
  localparam logic [1:0] PH_SPACE = 2'd2;

  logic [1:0]              phase_q, phase_d;
  logic [15:0]             tick_q, tick_d;
  logic [7:0]              idx_q, idx_d;
  logic [15:0]             held_q, held_d;
  logic [COMMAND_BITS-1:0] cmd_q, cmd_d;

  logic                    mark;
  logic [15:0]             tick_inc;
  logic [15:0]             ticks_a;
  logic [7:0]              idx_a, idx_b;
  logic [15:0]             held_a, held_b;
  logic [COMMAND_BITS-1:0] cmd_a, cmd_b;

  assign mark     = !level_i;
  assign tick_inc = (tick_q == irpd_pkg::TICK_MAX) ? tick_q : tick_q + 16'd1;
  assign ticks_a  = (phase_q == PH_SPACE && !mark) ? tick_inc : tick_q;

  irpd_interval #(.COMMAND_BITS(COMMAND_BITS)) u_take_a (
    .cfg_i  (cfg_i),
    .idx_i  (idx_q),
    .ticks_i(ticks_a),
    .held_i (held_q),
    .cmd_i  (cmd_q),
    .idx_o  (idx_a),
    .held_o (held_a),
    .cmd_o  (cmd_a)
  );

  // A one-tick space with a timeout of one or less closes right after the mark.
  irpd_interval #(.COMMAND_BITS(COMMAND_BITS)) u_take_b (
    .cfg_i  (cfg_i),
    .idx_i  (idx_a),
    .ticks_i(16'd1),
    .held_i (held_a),
    .cmd_i  (cmd_a),
    .idx_o  (idx_b),
    .held_o (held_b),
    .cmd_o  (cmd_b)
  );

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    idx_d   = idx_q;
    held_d  = held_q;
    cmd_d   = cmd_q;
    emit_o  = 1'b0;
    res_o.command         = 8'(cmd_a);
    res_o.frame_intervals = idx_a;
    case (phase_q)
      PH_MARK: begin
        if (mark) begin
          tick_d = tick_inc;
        end else if (cfg_i.space_timeout <= 16'd1) begin
          phase_d = PH_IDLE;
          tick_d  = 16'd1;
          held_d  = held_b;
          cmd_d   = cmd_b;
          idx_d   = '0;
          emit_o  = 1'b1;
          res_o.command         = 8'(cmd_b);
          res_o.frame_intervals = idx_b;
        end else begin
          phase_d = PH_SPACE;
          tick_d  = 16'd1;
          idx_d   = idx_a;
          held_d  = held_a;
          cmd_d   = cmd_a;
        end
      end
      PH_SPACE: begin
        if (!mark) begin
          tick_d = tick_inc;
          if (tick_inc >= cfg_i.space_timeout) begin
            phase_d = PH_IDLE;
            held_d  = held_a;
            cmd_d   = cmd_a;
            idx_d   = '0;
            emit_o  = 1'b1;
          end
        end else begin
          phase_d = PH_MARK;
          tick_d  = 16'd1;
          held_d  = held_a;
          cmd_d   = cmd_a;
          if (tick_q > cfg_i.end_gap) begin
            idx_d  = '0;
            emit_o = 1'b1;
          end else begin
            idx_d = idx_a;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (mark) begin
          phase_d = PH_MARK;
          tick_d  = 16'd1;
          idx_d   = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      idx_q   <= '0;
      held_q  <= '0;
      cmd_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      idx_q   <= idx_d;
      held_q  <= held_d;
      cmd_q   <= cmd_d;
    end
  end

endmodule

>>> rtl/ir_pulse_distance_decoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder
// Pulse-distance infrared remote decoder, one receiver pin sample per word.
// ----------------------------------------------------------------------------
// The in_i channel carries one pin sample per timer tick (ir_level, low means
// mark). The out_o channel carries one word per finished frame: the command
// byte and the number of intervals measured in the frame.
// Four registers are set over the APB port (pair threshold, end gap, space
// timeout, first bit interval); pready is always high, and registers should
// only be written while no frame is being decoded.
// A sample is registered in the sample stage at acceptance and processed by the
// frame state logic when it leaves that stage; a frame ending on that sample is
// registered into the output stage in that step and held on out_o until taken.
// One sample is accepted every cycle while out_o does not stall.
// If out_o stalls while it holds a word, the sample stage holds one further
// sample and in_i.ready drops until the word is taken.
// Reset clears the frame state, the command bits and both channel stages,
// and loads the register defaults.
// ----------------------------------------------------------------------------
module ir_pulse_distance_decoder #(
  parameter int unsigned COMMAND_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  irpd_in_if.sink                        in_i,
  irpd_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [irpd_pkg::AddrWidth-1:0] paddr,
  input  logic [irpd_pkg::DataWidth-1:0] pwdata,
  output logic [irpd_pkg::DataWidth-1:0] prdata,
  output logic                           pready
);

  irpd_pkg::cfg_t cfg;
  irpd_pkg::res_t res;
  irpd_pkg::res_t res_q;
  logic           emit;
  logic           smp_valid_q;
  logic           smp_level_q;
  logic           out_valid_q;
  logic           advance;

  assign advance    = smp_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !smp_valid_q || advance;

  irpd_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  irpd_core #(.COMMAND_BITS(COMMAND_BITS)) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (advance),
    .level_i(smp_level_q),
    .emit_o (emit),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      smp_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      smp_level_q <= in_i.ir_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      res_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.command         = res_q.command;
  assign out_o.frame_intervals = res_q.frame_intervals;

  a_word_from_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(smp_valid_q))
    else $error("output word without a processed sample");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (smp_valid_q && out_valid_q))
    else $error("input stalled without a held word");

  a_frame_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.frame_intervals != 8'd0))
    else $error("frame word with no intervals");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the infrared pulse-distance decoder.
// Pin samples are pushed over the input channel as whole frames with random
// mark and space lengths, plus some noise. A frame tracker predicts every
// decoded word from the accepted samples and checks each word taken from the
// output channel. Register settings change between phases while the decoder
// is idle, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int CmdBits = 8;
  localparam int QuietLimit = 20000;
  localparam int LongHold = 400;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MARK,
    PH_SPACE
  } ir_phase_e;

  class ir_frame_tracker;
    logic [16:0] thr;
    logic [15:0] gap;
    logic [15:0] tmo;
    logic [7:0] fbi;
    ir_phase_e phase;
    logic [15:0] ticks;
    logic [7:0] idx;
    logic [15:0] held;
    logic [CmdBits-1:0] cmd;
    irpd_pkg::res_t frames_due[$];

    function new();
      thr = irpd_pkg::RST_PAIR_THRESHOLD;
      gap = irpd_pkg::RST_END_GAP;
      tmo = irpd_pkg::RST_SPACE_TIMEOUT;
      fbi = irpd_pkg::RST_FIRST_BIT_INTERVAL;
      phase = PH_IDLE;
      ticks = '0;
      idx = '0;
      held = '0;
      cmd = '0;
    endfunction

    function void set_reg(logic [1:0] ridx, logic [31:0] value);
      case (ridx)
        irpd_pkg::REG_PAIR_THRESHOLD: thr = value[16:0];
        irpd_pkg::REG_END_GAP: gap = value[15:0];
        irpd_pkg::REG_SPACE_TIMEOUT: tmo = value[15:0];
        default: fbi = value[7:0];
      endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] ridx);
      case (ridx)
        irpd_pkg::REG_PAIR_THRESHOLD: return 32'(thr);
        irpd_pkg::REG_END_GAP: return 32'(gap);
        irpd_pkg::REG_SPACE_TIMEOUT: return 32'(tmo);
        default: return 32'(fbi);
      endcase
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    // An interval taken while the index is saturated is timed but ignored.
    function void close_interval(logic [15:0] len);
      logic [7:0] rel;
      int pair;
      if (idx != irpd_pkg::INDEX_MAX) begin
        if (idx >= fbi) begin
          rel = idx - fbi;
          pair = int'(rel >> 1);
          if (!rel[0]) begin
            held = len;
          end else if (pair < CmdBits) begin
            cmd[CmdBits-1-pair] = (int'(held) + int'(len)) > int'(thr);
          end
        end
        idx++;
      end
    endfunction

    function void end_frame();
      irpd_pkg::res_t word;
      word.command = cmd[7:0];
      word.frame_intervals = idx;
      frames_due.push_back(word);
      idx = '0;
    endfunction

    function void note_sample(bit level);
      case (phase)
        PH_MARK: begin
          if (!level) begin
            if (ticks != irpd_pkg::TICK_MAX) ticks++;
          end else begin
            close_interval(ticks);
            phase = PH_SPACE;
            ticks = 16'd1;
            if (ticks >= tmo) begin
              close_interval(ticks);
              phase = PH_IDLE;
              end_frame();
            end
          end
        end
        PH_SPACE: begin
          if (level) begin
            if (ticks != irpd_pkg::TICK_MAX) ticks++;
            if (ticks >= tmo) begin
              close_interval(ticks);
              phase = PH_IDLE;
              end_frame();
            end
          end else begin
            close_interval(ticks);
            phase = PH_MARK;
            if (ticks > gap) end_frame();
            ticks = 16'd1;
          end
        end
        default: begin
          phase = PH_IDLE;
          if (!level) begin
            phase = PH_MARK;
            ticks = 16'd1;
            idx = '0;
          end
        end
      endcase
    endfunction

    function bit check_frame(irpd_pkg::res_t got, output string why);
      irpd_pkg::res_t want;
      why = "";
      if (frames_due.size() == 0) begin
        why = $sformatf("word %02h/%0d with no frame due", got.command, got.frame_intervals);
        return 1'b0;
      end
      want = frames_due.pop_front();
      if (got.command != want.command) begin
        why = {why, $sformatf(" command %02h, expected %02h", got.command, want.command)};
      end
      if (got.frame_intervals != want.frame_intervals) begin
        why = {why, $sformatf(" intervals %0d, expected %0d",
                              got.frame_intervals, want.frame_intervals)};
      end
      return why == "";
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [irpd_pkg::AddrWidth-1:0] paddr;
  logic [irpd_pkg::DataWidth-1:0] pwdata;
  logic [irpd_pkg::DataWidth-1:0] prdata;
  logic pready;

  irpd_in_if in_if ();
  irpd_out_if out_if ();

  ir_pulse_distance_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  ir_frame_tracker sb;
  int mismatches = 0;
  int samples_sent = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  // Receiver: random stalls, and a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      out_if.ready = 1'b0;
      hold_left--;
    end else begin
      out_if.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : take_word
    string why;
    irpd_pkg::res_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.command = out_if.command;
      got.frame_intervals = out_if.frame_intervals;
      if (!sb.check_frame(got, why)) begin
        report_mismatch(why);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_sample(bit level);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_if.valid = 1'b0;
      in_if.ir_level = $urandom_range(0, 1);
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.ir_level = level;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_sample(level);
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic push_run(bit level, int count);
    repeat (count) push_sample(level);
  endtask

  task automatic wait_frames_done();
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic apb_read_check(logic [1:0] ridx);
    logic [irpd_pkg::DataWidth-1:0] got;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {ridx, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    if (got !== sb.reg_value(ridx)) begin
      report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                ridx, got, sb.reg_value(ridx)));
    end
  endtask

  task automatic write_reg(logic [1:0] ridx, logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {ridx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(ridx, value);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    apb_read_check(ridx);
  endtask

  // Ends any open frame with spaces, drains the output and then sets all
  // four registers.
  task automatic apply_setup(int thr, int gap, int tmo, int fbi);
    while (sb.phase != PH_IDLE) push_sample(1'b1);
    wait_frames_done();
    repeat (8) @(negedge clk_i);
    write_reg(irpd_pkg::REG_PAIR_THRESHOLD, 32'(thr));
    write_reg(irpd_pkg::REG_END_GAP, 32'(gap));
    write_reg(irpd_pkg::REG_SPACE_TIMEOUT, 32'(tmo));
    write_reg(irpd_pkg::REG_FIRST_BIT_INTERVAL, 32'(fbi));
  endtask

  task automatic apply_random_setup();
    int gap;
    gap = $urandom_range(2, 8);
    apply_setup($urandom_range(2, 12), gap, gap + $urandom_range(2, 8), $urandom_range(0, 6));
  endtask

  task automatic send_random_frame();
    int mark_max;
    int space_max;
    int pairs;
    int gap;
    int tmo;
    gap = int'(sb.gap);
    tmo = int'(sb.tmo);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20)) push_sample($urandom_range(0, 1));
      return;
    end
    mark_max = int'(sb.thr) / 2 + 2;
    if (mark_max > 16) mark_max = 16;
    space_max = (gap < tmo - 1) ? gap : tmo - 1;
    if (space_max > 40) space_max = 40;
    if (space_max < 1) space_max = 1;
    if ($urandom_range(0, 7) == 0) begin
      pairs = $urandom_range(1, int'(sb.fbi) / 2 + 12);
    end else begin
      pairs = $urandom_range(1, 20);
    end
    if (pairs > 24) pairs = 24;
    repeat (pairs) begin
      push_run(1'b0, $urandom_range(1, mark_max));
      push_run(1'b1, $urandom_range(1, space_max));
    end
    push_run(1'b0, $urandom_range(1, mark_max));
    if (tmo <= 200 && ($urandom_range(0, 1) == 1 || gap + 1 >= tmo)) begin
      push_run(1'b1, tmo);
    end else begin
      push_run(1'b1, $urandom_range(gap + 1, gap + 3));
    end
  endtask

  task automatic run_frames(int count, bit mid_pause);
    int first;
    bit paused;
    first = samples_sent;
    paused = 1'b0;
    while (samples_sent - first < count) begin
      send_random_frame();
      if (mid_pause && !paused && samples_sent - first >= count / 2) begin
        paused = 1'b1;
        wait_frames_done();
        @(negedge clk_i);
      end
    end
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin
        send_gap_pct = 20;
        stall_pct = 76;
      end
      1: begin
        send_gap_pct = 76;
        stall_pct = 20;
      end
      default: begin
        send_gap_pct = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.ir_level = 1'b1;
    out_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    apb_read_check(irpd_pkg::REG_PAIR_THRESHOLD);
    apb_read_check(irpd_pkg::REG_END_GAP);
    apb_read_check(irpd_pkg::REG_SPACE_TIMEOUT);
    apb_read_check(irpd_pkg::REG_FIRST_BIT_INTERVAL);

    // Short frame with odd first bit interval, a timed-out space, and a long
    // space whose closing mark starts the next frame on the same tick.
    set_idling(0);
    apply_setup(4, 3, 5, 1);
    push_run(1'b0, 2);
    push_run(1'b1, 3);
    push_run(1'b0, 1);
    push_run(1'b1, 2);
    push_run(1'b0, 3);
    push_run(1'b1, 5);
    push_run(1'b0, 1);
    push_run(1'b1, 4);
    push_run(1'b0, 1);
    push_run(1'b1, 5);

    // A long mark against a wide threshold, then a frame long enough to
    // saturate the index.
    set_idling(0);
    apply_setup(65535, 2, 3, 0);
    push_run(1'b0, 40);
    push_run(1'b1, 1);
    push_run(1'b0, 1);
    push_run(1'b1, 3);
    apply_setup(1, 2, 3, 250);
    repeat (150) begin
      push_sample(1'b0);
      push_sample(1'b1);
    end
    push_run(1'b1, 3);

    set_idling(0);
    apply_setup(0, 0, 1, 0);
    hold_req++;
    run_frames(160, 1'b0);
    apply_random_setup();
    run_frames(160, 1'b0);

    set_idling(1);
    apply_setup(131071, 65535, 6, 254);
    run_frames(160, 1'b0);
    apply_random_setup();
    run_frames(160, 1'b1);

    set_idling(2);
    apply_setup(10, 5, 210, 1);
    run_frames(160, 1'b0);
    apply_random_setup();
    run_frames(160, 1'b0);

    wait_frames_done();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
